// ===== hw/rtl/pfrgb_pkg.sv =====
// Shared types, constants and lookup tables for the pixel format converter.
// Depends on nothing. Used by every module of the converter.

package pfrgb_pkg;

  // Source pixel layouts held in the format register.
  typedef enum logic [3:0] {
    FMT_RGB332   = 4'd0,
    FMT_XRGB444  = 4'd1,
    FMT_XRGB555  = 4'd2,
    FMT_RGB565   = 4'd3,
    FMT_XRGB555X = 4'd4,
    FMT_RGB565X  = 4'd5,
    FMT_BGR24    = 4'd6,
    FMT_RGB24    = 4'd7,
    FMT_BGR666   = 4'd8,
    FMT_XBGR32   = 4'd9,
    FMT_XRGB32   = 4'd10,
    FMT_YUYV     = 4'd11
  } pix_fmt_e;

  localparam int unsigned FMT_W      = 4;
  localparam int unsigned FIFO_DEPTH = 2;

  // Widths of the YUV arithmetic: chroma products and accumulators.
  localparam int unsigned TERM_W = 25;
  localparam int unsigned ACC_W  = 26;

  // BT.601 full-range coefficients in Q16.
  localparam logic signed [TERM_W-1:0] COEF_RV = 25'sd91881;
  localparam logic signed [TERM_W-1:0] COEF_GU = 25'sd22554;
  localparam logic signed [TERM_W-1:0] COEF_GV = 25'sd46802;
  localparam logic signed [TERM_W-1:0] COEF_BU = 25'sd116130;

  // Full-scale values of the channel widths that need a true rescale.
  localparam int unsigned MAX3 = 7;
  localparam int unsigned MAX5 = 31;
  localparam int unsigned MAX6 = 63;
  localparam int unsigned FULL8 = 255;

  typedef logic [63:0][7:0] lut64_t;

  // Rescale tables floor(v * 255 / (2^n - 1)), built at elaboration.
  function automatic lut64_t build_lut3();
    lut64_t t;
    t = '0;
    for (int i = 0; i <= int'(MAX3); i++) t[6'(i)] = 8'((i * FULL8) / MAX3);
    return t;
  endfunction

  function automatic lut64_t build_lut5();
    lut64_t t;
    t = '0;
    for (int i = 0; i <= int'(MAX5); i++) t[6'(i)] = 8'((i * FULL8) / MAX5);
    return t;
  endfunction

  function automatic lut64_t build_lut6();
    lut64_t t;
    t = '0;
    for (int i = 0; i <= int'(MAX6); i++) t[6'(i)] = 8'((i * FULL8) / MAX6);
    return t;
  endfunction

  localparam lut64_t LUT3 = build_lut3();
  localparam lut64_t LUT5 = build_lut5();
  localparam lut64_t LUT6 = build_lut6();

  // One classified group, as queued between the front and back ends.
  typedef struct packed {
    logic                     is_yuv;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [7:0]               y0;
    logic [7:0]               y1;
    logic signed [TERM_W-1:0] r_term;
    logic signed [TERM_W-1:0] g_term;
    logic signed [TERM_W-1:0] b_term;
  } work_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/pfrgb_front.sv =====
// Front end: decodes one source group by the format register.
// Depends on pfrgb_pkg (format codes, rescale tables, work_t).

module pfrgb_front (
  input  logic [pfrgb_pkg::FMT_W-1:0] fmt_i,
  input  logic [31:0]                 pix_i,
  output logic                        keep_o,
  output pfrgb_pkg::work_t            work_o
);

  logic [7:0]                          b0, b1, b2, b3;
  logic [15:0]                         w16;
  logic [23:0]                         w24;
  logic signed [7:0]                   u_s, v_s;
  logic signed [pfrgb_pkg::TERM_W-1:0] u_ext, v_ext;

  assign b0  = pix_i[7:0];
  assign b1  = pix_i[15:8];
  assign b2  = pix_i[23:16];
  assign b3  = pix_i[31:24];
  assign w16 = {b0, b1};
  assign w24 = {b0, b1, b2};

  // Chroma with the 128 offset removed: flipping the top bit gives b - 128.
  assign u_s   = $signed({~b1[7], b1[6:0]});
  assign v_s   = $signed({~b3[7], b3[6:0]});
  assign u_ext = pfrgb_pkg::TERM_W'(u_s);
  assign v_ext = pfrgb_pkg::TERM_W'(v_s);

  // Extract and rescale RGB channels, form YUYV terms, drop bad codes.
  always_comb begin
    work_o        = '0;
    keep_o        = 1'b1;
    work_o.y0     = b0;
    work_o.y1     = b2;
    work_o.r_term = pfrgb_pkg::COEF_RV * v_ext;
    work_o.g_term = -(pfrgb_pkg::COEF_GU * u_ext) - (pfrgb_pkg::COEF_GV * v_ext);
    work_o.b_term = pfrgb_pkg::COEF_BU * u_ext;
    case (fmt_i)
      pfrgb_pkg::FMT_RGB332: begin
        work_o.red   = pfrgb_pkg::LUT3[{3'b0, pix_i[7:5]}];
        work_o.green = pfrgb_pkg::LUT3[{3'b0, pix_i[4:2]}];
        work_o.blue  = {4{pix_i[1:0]}};
      end
      pfrgb_pkg::FMT_XRGB444: begin
        work_o.red   = {2{pix_i[11:8]}};
        work_o.green = {2{pix_i[7:4]}};
        work_o.blue  = {2{pix_i[3:0]}};
      end
      pfrgb_pkg::FMT_XRGB555: begin
        work_o.red   = pfrgb_pkg::LUT5[{1'b0, pix_i[14:10]}];
        work_o.green = pfrgb_pkg::LUT5[{1'b0, pix_i[9:5]}];
        work_o.blue  = pfrgb_pkg::LUT5[{1'b0, pix_i[4:0]}];
      end
      pfrgb_pkg::FMT_RGB565: begin
        work_o.red   = pfrgb_pkg::LUT5[{1'b0, pix_i[15:11]}];
        work_o.green = pfrgb_pkg::LUT6[pix_i[10:5]];
        work_o.blue  = pfrgb_pkg::LUT5[{1'b0, pix_i[4:0]}];
      end
      pfrgb_pkg::FMT_XRGB555X: begin
        work_o.red   = pfrgb_pkg::LUT5[{1'b0, w16[14:10]}];
        work_o.green = pfrgb_pkg::LUT5[{1'b0, w16[9:5]}];
        work_o.blue  = pfrgb_pkg::LUT5[{1'b0, w16[4:0]}];
      end
      pfrgb_pkg::FMT_RGB565X: begin
        work_o.red   = pfrgb_pkg::LUT5[{1'b0, w16[15:11]}];
        work_o.green = pfrgb_pkg::LUT6[w16[10:5]];
        work_o.blue  = pfrgb_pkg::LUT5[{1'b0, w16[4:0]}];
      end
      pfrgb_pkg::FMT_BGR24, pfrgb_pkg::FMT_XBGR32: begin
        work_o.red   = b2;
        work_o.green = b1;
        work_o.blue  = b0;
      end
      pfrgb_pkg::FMT_RGB24: begin
        work_o.red   = b0;
        work_o.green = b1;
        work_o.blue  = b2;
      end
      pfrgb_pkg::FMT_BGR666: begin
        work_o.red   = pfrgb_pkg::LUT6[w24[11:6]];
        work_o.green = pfrgb_pkg::LUT6[w24[17:12]];
        work_o.blue  = pfrgb_pkg::LUT6[w24[23:18]];
      end
      pfrgb_pkg::FMT_XRGB32: begin
        work_o.red   = b1;
        work_o.green = b2;
        work_o.blue  = b3;
      end
      pfrgb_pkg::FMT_YUYV: begin
        work_o.is_yuv = 1'b1;
      end
      default: begin
        // Undefined format codes drop the group.
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pfrgb_fifo.sv =====
// Short queue of classified groups between the front and back ends.
// Depends on pfrgb_pkg (work_t, fifo_stat_t).

module pfrgb_fifo #(
  parameter int unsigned Depth = pfrgb_pkg::FIFO_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pfrgb_pkg::work_t       entry_i,
  input  logic                   pop_i,
  output pfrgb_pkg::work_t       head_o,
  output pfrgb_pkg::fifo_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pfrgb_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/pfrgb_back.sv =====
// Back end: turns queued groups into output pixels, one beat per cycle unless stalled.
// Depends on pfrgb_pkg (work_t, fifo_stat_t, accumulator widths).

module pfrgb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfrgb_pkg::work_t      head_i,
  input  pfrgb_pkg::fifo_stat_t stat_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [23:0]           m_tdata_o,
  output logic                  m_tlast_o
);

  logic        valid_q, valid_d;
  logic        half_q, half_d;
  logic [23:0] data_q, data_d;
  logic        last_q, last_d;
  logic        load, take;
  logic [7:0]  y_sel;
  logic signed [pfrgb_pkg::ACC_W-1:0] base, acc_r, acc_g, acc_b;

  // Floor to integer and clamp to 0..255.
  function automatic logic [7:0] clamp_chan(logic signed [pfrgb_pkg::ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[pfrgb_pkg::ACC_W-1]) begin
      res = 8'd0;
    end else if (acc[24]) begin
      res = 8'hFF;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

  assign load = !valid_q || m_tready_i;
  assign take = load && !stat_i.empty;

  // Left pixel of a pair uses Y0, right pixel Y1.
  assign y_sel = half_q ? head_i.y1 : head_i.y0;
  assign base  = $signed({2'b00, y_sel, 16'h0000});
  assign acc_r = base + pfrgb_pkg::ACC_W'(head_i.r_term);
  assign acc_g = base + pfrgb_pkg::ACC_W'(head_i.g_term);
  assign acc_b = base + pfrgb_pkg::ACC_W'(head_i.b_term);

  // Output register load and pair sequencing.
  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    data_d  = data_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = take;
    end
    if (take) begin
      if (head_i.is_yuv) begin
        data_d = {clamp_chan(acc_b), clamp_chan(acc_g), clamp_chan(acc_r)};
      end else begin
        data_d = {head_i.blue, head_i.green, head_i.red};
      end
      if (head_i.is_yuv && !half_q) begin
        last_d = 1'b0;
        half_d = 1'b1;
      end else begin
        last_d = 1'b1;
        half_d = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;

endmodule

// ===== hw/rtl/pixel_format_to_rgb24.sv =====
// Packed RGB / YUYV to 24-bit RGB converter, top level.
// Uses the channels below; format register written over the cfg channel.
// s_axis: one beat carries one source group of four bytes, byte 0 lowest.
// m_axis: one beat per output pixel; tdata holds red, green, blue from bit 0,
//   tlast is high on the final pixel of a group, low on a YUYV left pixel.
// cfg: one beat writes the 4-bit pixel format; always ready. Write it only
//   while no group is in flight. Codes 12 to 15 accept and drop groups.
// The first pixel of a group reaches m_axis through the queue and then the
//   output register; a YUYV right pixel is sent after its left pixel.
// RGB layouts give one pixel per group, YUYV two; the output register sends
//   one pixel per cycle while the receiver is ready and a group is queued.
// A queue of FIFO_DEPTH groups between the decode front end and the pixel
//   back end lets input continue while the receiver stalls; when it fills,
//   s_axis_tready drops.
// Reset clears the queue and the output valid and pair flags, and sets rgb332.
// Depends on pfrgb_pkg, pfrgb_front, pfrgb_fifo, pfrgb_back.

module pixel_format_to_rgb24 #(
  parameter int unsigned FifoDepth = pfrgb_pkg::FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pfrgb_pkg::FMT_W-1:0] cfg_data_i,    // pixel_format
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // pixel_bytes
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // red, green, blue
  output logic                        m_axis_tlast   // last_of_group
);

  logic [pfrgb_pkg::FMT_W-1:0] fmt_q;
  logic                        keep, push, pop;
  pfrgb_pkg::work_t            work, head;
  pfrgb_pkg::fifo_stat_t       stat;

  // Format register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= pfrgb_pkg::FMT_RGB332;
    end else if (cfg_valid_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // Front end decodes each accepted beat into the queue.
  pfrgb_front u_front (
    .fmt_i  (fmt_q),
    .pix_i  (s_axis_tdata),
    .keep_o (keep),
    .work_o (work)
  );

  assign s_axis_tready = !stat.full;
  assign push          = s_axis_tvalid && s_axis_tready && keep;

  pfrgb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (work),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (stat)
  );

  // Back end emits pixels through the output register.
  pfrgb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .stat_i     (stat),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/pfrgb_checker.sv =====
// Port-level checks for the pixel format converter, bound to its top level.
// Depends on pfrgb_pkg (format codes) and pixel_format_to_rgb24.

module pfrgb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [pfrgb_pkg::FMT_W-1:0] cfg_data_i,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [31:0]                 s_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [23:0]                 m_axis_tdata,
  input logic                        m_axis_tlast
);

  logic [pfrgb_pkg::FMT_W-1:0] fmt_seen_q;
  logic                        out_beat;

  // Track the format written over the configuration channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_seen_q <= pfrgb_pkg::FMT_RGB332;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_seen_q <= cfg_data_i;
    end
  end

  assign out_beat = m_axis_tvalid && m_axis_tready;

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // A YUYV left pixel is followed at once by its right pixel.
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("left pixel not followed by right pixel");

  // RGB layouts give exactly one pixel per group.
  a_rgb_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (fmt_seen_q != pfrgb_pkg::FMT_YUYV) |-> m_axis_tlast)
    else $error("split pixel under an RGB format");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid after reset");

  // After an accepted input beat with known tdata, input ready is not unknown.
  a_no_x_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata) |=>
      !$isunknown(s_axis_tready))
    else $error("input ready unknown after a beat");

endmodule

bind pixel_format_to_rgb24 pfrgb_checker u_pfrgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_data_i    (cfg_data_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the packed RGB / YUYV to RGB888 converter.
// Depends on pfrgb_pkg and pixel_format_to_rgb24; a local predictor checks every output beat.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned RANDOM_GRPS = 1300;
  localparam int unsigned PHASE_GRPS  = 60;

  // One expected output pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [pfrgb_pkg::FMT_W-1:0] cfg_data_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata;   // pixel_bytes
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [23:0]                 m_axis_tdata;   // red, green, blue
  logic                        m_axis_tlast;   // last_of_group

  logic [pfrgb_pkg::FMT_W-1:0] fmt_model;
  pixel_t                      pixel_q[$];
  logic                        tx_idle_en;
  logic                        rx_idle_en;
  int unsigned                 err_count;
  int unsigned                 groups_sent;
  int unsigned                 pixels_checked;
  int unsigned                 formats_set;
  int unsigned                 idle_cycles;

  pixel_format_to_rgb24 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 50 MHz clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Extract an n-bit channel and stretch it to 8 bits with floor.
  function automatic logic [7:0] rescale_field(logic [31:0] word, int pos, int n);
    int unsigned mask;
    int unsigned raw;
    mask = (1 << n) - 1;
    raw  = (word >> pos) & mask;
    return 8'((raw * 255) / mask);
  endfunction

  // Floor a Q16 accumulator to an integer and clamp it to 0..255.
  function automatic logic [7:0] clamp_q16(int acc);
    int whole;
    if (acc < 0) return 8'd0;
    whole = acc >>> 16;
    return (whole > 255) ? 8'd255 : 8'(whole);
  endfunction

  function automatic pixel_t yuv_to_rgb(int luma, int u, int v, logic last);
    pixel_t px;
    int     base;
    base     = luma * 65536;
    px.red   = clamp_q16(base + 91881 * v);
    px.green = clamp_q16(base - 22554 * u - 46802 * v);
    px.blue  = clamp_q16(base + 116130 * u);
    px.last  = last;
    return px;
  endfunction

  // Queue the pixels that one accepted group must produce under the current format.
  task automatic predict_pixels(input logic [31:0] bytes);
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] word;
    int          rp, rn, gp, gn, bp, bn;
    pixel_t      px;
    b0   = bytes[7:0];
    b1   = bytes[15:8];
    b2   = bytes[23:16];
    b3   = bytes[31:24];
    word = bytes;
    case (fmt_model)
      pfrgb_pkg::FMT_RGB332:   begin rp = 5;  rn = 3; gp = 2;  gn = 3; bp = 0;  bn = 2; end
      pfrgb_pkg::FMT_XRGB444:  begin rp = 8;  rn = 4; gp = 4;  gn = 4; bp = 0;  bn = 4; end
      pfrgb_pkg::FMT_XRGB555:  begin rp = 10; rn = 5; gp = 5;  gn = 5; bp = 0;  bn = 5; end
      pfrgb_pkg::FMT_RGB565:   begin rp = 11; rn = 5; gp = 5;  gn = 6; bp = 0;  bn = 5; end
      pfrgb_pkg::FMT_XRGB555X: begin
        rp = 10; rn = 5; gp = 5; gn = 5; bp = 0; bn = 5;
        word = {16'd0, b0, b1};
      end
      pfrgb_pkg::FMT_RGB565X:  begin
        rp = 11; rn = 5; gp = 5; gn = 6; bp = 0; bn = 5;
        word = {16'd0, b0, b1};
      end
      pfrgb_pkg::FMT_BGR24:    begin rp = 16; rn = 8; gp = 8;  gn = 8; bp = 0;  bn = 8; end
      pfrgb_pkg::FMT_RGB24:    begin rp = 0;  rn = 8; gp = 8;  gn = 8; bp = 16; bn = 8; end
      pfrgb_pkg::FMT_BGR666:   begin
        rp = 6; rn = 6; gp = 12; gn = 6; bp = 18; bn = 6;
        word = {8'd0, b0, b1, b2};
      end
      pfrgb_pkg::FMT_XBGR32:   begin rp = 16; rn = 8; gp = 8;  gn = 8; bp = 0;  bn = 8; end
      pfrgb_pkg::FMT_XRGB32:   begin rp = 8;  rn = 8; gp = 16; gn = 8; bp = 24; bn = 8; end
      default:                 begin rp = 0;  rn = 0; gp = 0;  gn = 0; bp = 0;  bn = 0; end
    endcase
    if (fmt_model == pfrgb_pkg::FMT_YUYV) begin
      // Both pixels share chroma; the left one uses Y0, the right one Y1.
      pixel_q.push_back(yuv_to_rgb(int'(b0), int'(b1) - 128, int'(b3) - 128, 1'b0));
      pixel_q.push_back(yuv_to_rgb(int'(b2), int'(b1) - 128, int'(b3) - 128, 1'b1));
    end else if (fmt_model < pfrgb_pkg::FMT_YUYV) begin
      px.red   = rescale_field(word, rp, rn);
      px.green = rescale_field(word, gp, gn);
      px.blue  = rescale_field(word, bp, bn);
      px.last  = 1'b1;
      pixel_q.push_back(px);
    end
    // Undefined format codes drop the group without output.
  endtask

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Send one input beat after a random gap; called and returning at a falling edge.
  task automatic send_group(input logic [31:0] bytes);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = bytes;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixels(bytes);
    groups_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending, wait for every expected pixel, then let the pipeline settle.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Format register write; only issued while the block is idle.
  task automatic write_format(input logic [pfrgb_pkg::FMT_W-1:0] code);
    wait_drained();
    cfg_data_i  = code;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    fmt_model = code;
    formats_set++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random group: mostly uniform, sometimes built from corner byte values.
  function automatic logic [31:0] pick_group_bytes();
    logic [7:0] corners[6];
    logic [31:0] bytes;
    corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 4; k++) bytes[8*k +: 8] = corners[$urandom_range(0, 5)];
    end else begin
      bytes = $urandom();
    end
    return bytes;
  endfunction

  // The format after reset must be rgb332, without any register write.
  task automatic test_reset_format();
    send_group(32'h0000_0000);
    send_group(32'hFFFF_FFFF);
    send_group(32'h0000_00E0);
  endtask

  // Every packed RGB layout from xrgb444 on, all bits set, unused bytes included.
  task automatic test_rgb_layouts();
    for (int f = int'(pfrgb_pkg::FMT_XRGB444); f <= int'(pfrgb_pkg::FMT_XRGB32); f++) begin
      write_format(pfrgb_pkg::FMT_W'(f));
      send_group(32'hFFFF_FFFF);
    end
  endtask

  // YUYV corners: black, white, and chroma pushing channels past both clamps.
  task automatic test_yuyv_corners();
    write_format(pfrgb_pkg::FMT_YUYV);
    send_group(32'h8000_8000);
    send_group(32'h80FF_80FF);
    send_group(32'hFF00_FF00);
    send_group(32'h00FF_00FF);
    send_group(32'hFFFF_FFFF);
    send_group(32'h0000_0000);
  endtask

  // Undefined format codes accept groups and produce nothing.
  task automatic test_undefined_formats();
    write_format(4'd12);
    send_group(32'h1234_5678);
    write_format(4'd15);
    send_group(32'hFFFF_FFFF);
    send_group(32'h0000_0000);
  endtask

  // Random groups in phases of one format each, with varied idling on both sides.
  task automatic test_random_mix();
    int unsigned                 counted;
    int                          phase;
    logic [pfrgb_pkg::FMT_W-1:0] code;
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_GRPS) begin
      // Now and then an undefined format between phases; its groups do not count.
      if (phase % 4 == 3) begin
        write_format(pfrgb_pkg::FMT_W'($urandom_range(12, 15)));
        repeat (10) send_group($urandom());
      end
      code = (phase < 12) ? pfrgb_pkg::FMT_W'(phase) :
                            pfrgb_pkg::FMT_W'($urandom_range(0, 11));
      write_format(code);
      if (phase % 5 == 2) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      for (int i = 0; i < PHASE_GRPS; i++) begin
        // Hold the sender off until the output side has caught up.
        if (i == PHASE_GRPS / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) wait_drained();
        send_group(pick_group_bytes());
      end
      counted += PHASE_GRPS;
      phase++;
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Output sink: random stall before each beat, sampled at the rising edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int stall;
      @(negedge clk_i);
      stall = rx_idle_en ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!(rst_ni && m_axis_tvalid));
    end
  end

  // Compare each output beat with the oldest expected pixel.
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        report_error($sformatf("unexpected pixel tdata=%06h tlast=%0b",
                               m_axis_tdata, m_axis_tlast));
      end else begin
        want = pixel_q.pop_front();
        if (m_axis_tdata[7:0] !== want.red)
          report_error($sformatf("pixel %0d red: expected %02h got %02h",
                                 pixels_checked, want.red, m_axis_tdata[7:0]));
        if (m_axis_tdata[15:8] !== want.green)
          report_error($sformatf("pixel %0d green: expected %02h got %02h",
                                 pixels_checked, want.green, m_axis_tdata[15:8]));
        if (m_axis_tdata[23:16] !== want.blue)
          report_error($sformatf("pixel %0d blue: expected %02h got %02h",
                                 pixels_checked, want.blue, m_axis_tdata[23:16]));
        if (m_axis_tlast !== want.last)
          report_error($sformatf("pixel %0d tlast: expected %0b got %0b",
                                 pixels_checked, want.last, m_axis_tlast));
        pixels_checked++;
      end
    end
  end

  // Hang detection: too many cycles in a row with no beat on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d pixels still expected",
                 IDLE_LIMIT, pixel_q.size());
        $display("tb_top: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    fmt_model      = pfrgb_pkg::FMT_RGB332;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    err_count      = 0;
    groups_sent    = 0;
    pixels_checked = 0;
    formats_set    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_format();
    test_rgb_layouts();
    test_yuyv_corners();
    test_undefined_formats();
    test_random_mix();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pixel_q.size() != 0)
      report_error($sformatf("%0d expected pixels never arrived", pixel_q.size()));
    $display("Run covered %0d input groups and %0d output pixels over %0d format writes,",
             groups_sent, pixels_checked, formats_set);
    $display("all twelve layouts plus undefined codes, with %0d mismatches.", err_count);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== pixel_format_to_rgb24.f =====
hw/rtl/pfrgb_pkg.sv
hw/rtl/pfrgb_front.sv
hw/rtl/pfrgb_fifo.sv
hw/rtl/pfrgb_back.sv
hw/rtl/pixel_format_to_rgb24.sv
hw/rtl/pfrgb_checker.sv
dv/tb_top.sv
